/* rtl/core/order_table_position_tracker_unit_macros.svh */
// Assertion macros for the order table and position tracker checker.
// Needs nothing but a clock and a reset from the module that expands them.
`ifndef ORDER_TABLE_POSITION_TRACKER_UNIT_MACROS_SVH
`define ORDER_TABLE_POSITION_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define OTPT_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define OTPT_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

/* rtl/core/otpt_pkg.sv */
// Shared types and codes for the order table and position tracker.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package otpt_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 1024;
   localparam int ID_W                = 10;
   localparam int LIMIT_W             = 11;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

   // operation codes
   localparam logic [2:0] OP_CREATE = 3'd0;
   localparam logic [2:0] OP_ACK    = 3'd1;
   localparam logic [2:0] OP_FILL   = 3'd2;
   localparam logic [2:0] OP_CANCEL = 3'd3;
   localparam logic [2:0] OP_QUERY  = 3'd4;

   // error codes
   localparam logic [2:0] ERR_OK       = 3'd0;
   localparam logic [2:0] ERR_FULL     = 3'd1;
   localparam logic [2:0] ERR_BAD_ID   = 3'd2;
   localparam logic [2:0] ERR_OVERFILL = 3'd3;
   localparam logic [2:0] ERR_CLOSED   = 3'd4;

   // order status codes
   localparam logic [2:0] STATUS_PENDING   = 3'd0;
   localparam logic [2:0] STATUS_LIVE      = 3'd1;
   localparam logic [2:0] STATUS_PARTIAL   = 3'd2;
   localparam logic [2:0] STATUS_FILLED    = 3'd3;
   localparam logic [2:0] STATUS_CANCELLED = 3'd4;

   typedef struct packed {
      logic [2:0]         operation;
      logic [ID_W-1:0]    target_id;
      logic signed [63:0] limit_price;
      logic [31:0]        quantity;
      logic               buy_side;
   } req_type;

   typedef struct packed {
      logic [2:0]         error_code;
      logic [ID_W-1:0]    result_id;
      logic [2:0]         order_status;
      logic signed [63:0] order_price;
      logic [31:0]        order_quantity;
      logic [31:0]        order_filled;
      logic               order_buy_side;
      logic signed [63:0] position;
      logic signed [63:0] cash_balance;
   } rsp_type;

   // one table row: price, size, filled size, side and status
   typedef struct packed {
      logic [63:0] price;
      logic [31:0] quantity;
      logic [31:0] filled;
      logic        buy_side;
      logic [2:0]  status;
   } entry_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EVAL,
      FSM_MULT,
      FSM_FINISH
   } ctl_state_type;

   typedef enum logic [2:0] {
      MUL_IDLE,
      MUL_LO,
      MUL_HI,
      MUL_SUM,
      MUL_DONE
   } mul_state_type;

endpackage

/* rtl/core/otpt_entry_ram.sv */
// Order table storage: one write port, one read port, registered read data.
// Depends on otpt_pkg for the row type.
`timescale 1ns / 1ps

module otpt_entry_ram
   import otpt_pkg::*;
#(
   parameter int DEPTH = TABLE_DEPTH_DEFAULT,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/otpt_fill_mul.sv */
// Fill value unit: low 64 bits of quantity times price, one 32x32 multiplier
// used twice, then one add. Depends on otpt_pkg for its state type.
`timescale 1ns / 1ps

module otpt_fill_mul
   import otpt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] price,
   input  logic [31:0] quantity,
   output logic        done,
   output logic [63:0] value
);

   mul_state_type state_ff, state_in;
   logic [63:0]   price_ff;
   logic [31:0]   qty_ff;
   logic [63:0]   lo_ff;
   logic [31:0]   hi_ff;
   logic [63:0]   value_ff;
   logic [31:0]   mul_a;
   logic [63:0]   product;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MUL_IDLE: if (start) state_in = MUL_LO;
         MUL_LO:   state_in = MUL_HI;
         MUL_HI:   state_in = MUL_SUM;
         MUL_SUM:  state_in = MUL_DONE;
         MUL_DONE: state_in = MUL_IDLE;
         default:  state_in = MUL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MUL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // low half of the price first, then the high half
   assign mul_a   = (state_ff == MUL_LO) ? price_ff[31:0] : price_ff[63:32];
   assign product = {32'b0, mul_a} * {32'b0, qty_ff};

   always_ff @(posedge clock) begin
      if (state_ff == MUL_IDLE && start) begin
         price_ff <= price;
         qty_ff   <= quantity;
      end
      if (state_ff == MUL_LO) begin
         lo_ff <= product;
      end
      if (state_ff == MUL_HI) begin
         hi_ff <= product[31:0];
      end
      if (state_ff == MUL_SUM) begin
         value_ff <= lo_ff + {hi_ff, 32'b0};
      end
   end

   assign done  = (state_ff == MUL_DONE);
   assign value = value_ff;

endmodule

/* rtl/core/order_table_position_tracker_unit.sv */
// Order table and position tracker: takes one order event at a time, reads the
// addressed row, applies the operation and writes the row back. A create,
// acknowledge, cancel or query passes the idle, evaluate and finish states; a
// fill also waits in the multiply state for the two passes of the shared
// 32x32 multiplier and the add that forms the 64-bit trade value. The result
// sits in an output register; the next request is taken while it still waits.
`timescale 1ns / 1ps

module order_table_position_tracker_unit
   import otpt_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [LIMIT_W-1:0] csr_data
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   ctl_state_type      state_ff, state_in;
   logic [LIMIT_W-1:0] order_limit_ff;
   logic [CNT_W-1:0]   next_id_ff, next_id_in;
   logic [63:0]        holdings_ff, holdings_in;
   logic [63:0]        cash_ff, cash_in;
   req_type            req_ff;
   logic [IDX_W-1:0]   addr_ff;
   logic [2:0]         err_ff, err_in;
   logic [ID_W-1:0]    rid_ff, rid_in;
   logic               upd_ff, upd_in;
   logic               show_ff, show_in;
   logic               totals_ff, totals_in;
   entry_type          entry_ff, entry_in;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   logic               accept;
   logic               mul_start;
   logic               finish_go;
   entry_type          rd_entry;
   logic               mul_done;
   logic [63:0]        mul_value;
   logic [IDX_W-1:0]   rd_addr;
   logic [CMP_W-1:0]   limit_ext, next_ext, id_ext;
   logic               table_full, bad_id;
   logic [31:0]        open_qty, filled_sum;
   rsp_type            rsp_in;

   otpt_entry_ram #(
      .DEPTH(TABLE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (finish_go && upd_ff),
      .wr_addr(addr_ff),
      .wr_data(entry_ff),
      .rd_en  (accept),
      .rd_addr(rd_addr),
      .rd_data(rd_entry)
   );

   otpt_fill_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .price   (rd_entry.price),
      .quantity(req_ff.quantity),
      .done    (mul_done),
      .value   (mul_value)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE:   if (req_valid) state_in = FSM_EVAL;
         FSM_EVAL:   state_in = totals_in ? FSM_MULT : FSM_FINISH;
         FSM_MULT:   if (mul_done) state_in = FSM_FINISH;
         FSM_FINISH: if (!rsp_valid_ff || rsp_ready) state_in = FSM_IDLE;
         default:    state_in = FSM_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = 1'b0;
      mul_start = 1'b0;
      finish_go = 1'b0;
      unique case (state_ff)
         FSM_IDLE:   req_ready = 1'b1;
         FSM_EVAL:   mul_start = totals_in;
         FSM_MULT:   ;
         FSM_FINISH: finish_go = !rsp_valid_ff || rsp_ready;
         default:    ;
      endcase
   end

   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rd_addr   = (req_data.operation == OP_CREATE) ? IDX_W'(next_id_ff)
                                                        : IDX_W'(req_data.target_id);

   assign limit_ext  = (CMP_W'(order_limit_ff) < CMP_W'(TABLE_DEPTH))
                     ? CMP_W'(order_limit_ff) : CMP_W'(TABLE_DEPTH);
   assign next_ext   = CMP_W'(next_id_ff);
   assign id_ext     = CMP_W'(req_ff.target_id);
   assign table_full = (next_ext >= limit_ext);
   assign bad_id     = (id_ext >= next_ext) || (id_ext >= CMP_W'(TABLE_DEPTH));
   assign open_qty   = rd_entry.quantity - rd_entry.filled;
   assign filled_sum = rd_entry.filled + req_ff.quantity;

   // apply the operation to the row just read
   always_comb begin
      err_in     = ERR_OK;
      rid_in     = req_ff.target_id;
      upd_in     = 1'b0;
      show_in    = 1'b0;
      totals_in  = 1'b0;
      entry_in   = rd_entry;
      next_id_in = next_id_ff;
      unique case (req_ff.operation)
         OP_CREATE: begin
            if (table_full) begin
               err_in = ERR_FULL;
               rid_in = '0;
            end else begin
               entry_in.price    = req_ff.limit_price;
               entry_in.quantity = req_ff.quantity;
               entry_in.filled   = '0;
               entry_in.buy_side = req_ff.buy_side;
               entry_in.status   = STATUS_PENDING;
               rid_in     = ID_W'(next_id_ff);
               upd_in     = 1'b1;
               show_in    = 1'b1;
               next_id_in = next_id_ff + CNT_W'(1);
            end
         end
         OP_ACK, OP_FILL, OP_CANCEL, OP_QUERY: begin
            if (bad_id) begin
               err_in = ERR_BAD_ID;
            end else begin
               show_in = 1'b1;
               if (req_ff.operation == OP_ACK) begin
                  entry_in.status = STATUS_LIVE;
                  upd_in = 1'b1;
               end else if (req_ff.operation == OP_FILL) begin
                  if (req_ff.quantity > open_qty) begin
                     err_in = ERR_OVERFILL;
                  end else begin
                     entry_in.filled = filled_sum;
                     entry_in.status = (filled_sum == rd_entry.quantity)
                                     ? STATUS_FILLED : STATUS_PARTIAL;
                     upd_in    = 1'b1;
                     totals_in = 1'b1;
                  end
               end else if (req_ff.operation == OP_CANCEL) begin
                  if (rd_entry.status == STATUS_FILLED ||
                      rd_entry.status == STATUS_CANCELLED) begin
                     err_in = ERR_CLOSED;
                  end else begin
                     entry_in.status = STATUS_CANCELLED;
                     upd_in = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   // running totals move once, on the cycle the result is loaded
   always_comb begin
      holdings_in = holdings_ff;
      cash_in     = cash_ff;
      if (finish_go && totals_ff) begin
         if (entry_ff.buy_side) begin
            holdings_in = holdings_ff + {32'b0, req_ff.quantity};
            cash_in     = cash_ff - mul_value;
         end else begin
            holdings_in = holdings_ff - {32'b0, req_ff.quantity};
            cash_in     = cash_ff + mul_value;
         end
      end
   end

   always_comb begin
      rsp_in                = '0;
      rsp_in.error_code     = err_ff;
      rsp_in.result_id      = rid_ff;
      if (show_ff) begin
         rsp_in.order_status   = entry_ff.status;
         rsp_in.order_price    = entry_ff.price;
         rsp_in.order_quantity = entry_ff.quantity;
         rsp_in.order_filled   = entry_ff.filled;
         rsp_in.order_buy_side = entry_ff.buy_side;
      end
      rsp_in.position       = holdings_in;
      rsp_in.cash_balance   = cash_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= FSM_IDLE;
         order_limit_ff <= LIMIT_RESET;
         next_id_ff     <= '0;
         holdings_ff    <= '0;
         cash_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         holdings_ff <= holdings_in;
         cash_ff     <= cash_in;
         if (csr_valid && csr_ready) begin
            order_limit_ff <= csr_data;
         end
         if (state_ff == FSM_EVAL) begin
            next_id_ff <= next_id_in;
         end
         if (finish_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold the request and the evaluated row for the rest of the item
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff  <= req_data;
         addr_ff <= rd_addr;
      end
      if (state_ff == FSM_EVAL) begin
         err_ff    <= err_in;
         rid_ff    <= rid_in;
         upd_ff    <= upd_in;
         show_ff   <= show_in;
         totals_ff <= totals_in;
         entry_ff  <= entry_in;
      end
      if (finish_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/core/otpt_checker.sv */
// Port-level checks for the order table and position tracker, bound to the top.
// Depends on otpt_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "order_table_position_tracker_unit_macros.svh"

module otpt_checker
   import otpt_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input rsp_type            rsp_data
);

   // a stalled result transfer keeps its payload
   `OTPT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // one item at a time: no request right after a request transfer
   `OTPT_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "request taken on back-to-back cycles")

   // a full table shows no order
   `OTPT_ASSERT_NOW(a_full_empty, clock, reset, rsp_valid && rsp_data.error_code == ERR_FULL, rsp_data.result_id == '0 && rsp_data.order_quantity == '0 && rsp_data.order_price == '0, "table full result carries an order")

   // a bad id shows no order fields
   `OTPT_ASSERT_NOW(a_bad_id_empty, clock, reset, rsp_valid && rsp_data.error_code == ERR_BAD_ID, rsp_data.order_filled == '0 && rsp_data.order_status == STATUS_PENDING && !rsp_data.order_buy_side, "invalid id result carries an order")

endmodule

bind order_table_position_tracker_unit otpt_checker u_otpt_checker (.*);
